### rtl/core/padded_integer_formatter_defines.svh
// assertion macros shared by the padded integer formatter rtl
// no dependencies; included by files that carry concurrent checks
`ifndef PADDED_INTEGER_FORMATTER_DEFINES_SVH
`define PADDED_INTEGER_FORMATTER_DEFINES_SVH

// same-cycle implication, checking off during reset
`define PIF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checking off during reset
`define PIF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pif_pkg.sv
// shared types and constants for the padded integer formatter
// no dependencies; imported by every module of the block
package pif_pkg;

    // field widths
    localparam int unsigned NUM_W   = 32;
    localparam int unsigned RADIX_W = 5;
    localparam int unsigned WIDTH_W = 6;
    localparam int unsigned PAD_W   = 2;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned DIGIT_W = 4;

    // digit store
    localparam int unsigned DIGIT_SLOTS = 12;
    localparam int unsigned LEN_W       = $clog2(DIGIT_SLOTS + 1);
    localparam int unsigned IDX_W       = $clog2(DIGIT_SLOTS);

    // divider: quotient bits retired per cycle
    localparam int unsigned CHUNK_BITS  = 8;
    localparam int unsigned CHUNKS      = NUM_W / CHUNK_BITS;
    localparam int unsigned CHUNK_CNT_W = $clog2(CHUNKS);

    // operand limits
    localparam int unsigned RADIX_MIN = 8;
    localparam int unsigned RADIX_MAX = 16;
    localparam int unsigned RADIX_DEC = 10;
    localparam int unsigned WIDTH_MAX = 32;

    // ascii
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

    // microprogram
    localparam int unsigned UPC_W = 4;
    typedef logic [UPC_W-1:0] t_upc;

    localparam t_upc U_IDLE     = t_upc'(0);
    localparam t_upc U_DIV      = t_upc'(1);
    localparam t_upc U_SIGN     = t_upc'(2);
    localparam t_upc U_FILL     = t_upc'(3);
    localparam t_upc U_MINUS    = t_upc'(4);
    localparam t_upc U_PAD_CHK  = t_upc'(5);
    localparam t_upc U_LPAD     = t_upc'(6);
    localparam t_upc U_TEXT     = t_upc'(7);
    localparam t_upc U_RPAD_CHK = t_upc'(8);
    localparam t_upc U_RPAD     = t_upc'(9);
    localparam t_upc U_DONE     = t_upc'(10);

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV,
        OP_SIGN,
        OP_FILL,
        OP_EMIT_MINUS,
        OP_EMIT_FILL,
        OP_EMIT_TEXT
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_DIV_AGAIN,
        C_LEFT_JUST,
        C_RIGHT_JUST,
        C_FILL_MORE,
        C_TEXT_MORE
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  target;
    } t_uword;

    typedef struct packed {
        logic no_in;
        logic div_again;
        logic left_just;
        logic fill_more;
        logic text_more;
        logic hold;
        logic fire_last;
    } t_dp_status;

endpackage

### rtl/core/padded_integer_formatter.sv
// top level of the padded integer formatter: rom, sequencer and datapath
// depends on pif_pkg, pif_ucode_rom, pif_sequencer, pif_datapath and the defines header
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------------------
//   in      | into      | i_in_valid / o_in_stall   | number radix signed_mode field_width
//           |           |                           | pad_mode upper_case
//   out     | out of    | o_out_valid / i_out_stall | character last
//
// one value at a time: a load step, the radix divider for each digit
// (8 quotient bits a cycle), the sign and fill steps, then the minus, pad and text
// steps at one character beat per cycle unless the output stalls; 11 digits at most (radix 8), 10 in decimal
// synchronous active-low reset returns the step counter to idle and empties the output
// a stalled output beat freezes the step counter on the emitting step
`include "padded_integer_formatter_defines.svh"

module padded_integer_formatter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [pif_pkg::NUM_W-1:0]   i_number,
    input  logic [pif_pkg::RADIX_W-1:0] i_radix,
    input  logic                        i_signed_mode,
    input  logic [pif_pkg::WIDTH_W-1:0] i_field_width,
    input  logic [pif_pkg::PAD_W-1:0]   i_pad_mode,
    input  logic                        i_upper_case,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [pif_pkg::CHAR_W-1:0]  o_character,
    output logic                        o_last
);
    import pif_pkg::*;

    t_upc       upc;
    t_uword     uword;
    t_dp_status status;
    logic       in_acc;

    pif_ucode_rom u_rom (
        .i_upc   (upc),
        .o_uword (uword)
    );

    pif_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_uword  (uword),
        .i_status (status),
        .o_upc    (upc)
    );

    pif_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_uword       (uword),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_number      (i_number),
        .i_radix       (i_radix),
        .i_signed_mode (i_signed_mode),
        .i_field_width (i_field_width),
        .i_pad_mode    (i_pad_mode),
        .i_upper_case  (i_upper_case),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_character   (o_character),
        .o_last        (o_last),
        .o_status      (status)
    );

    assign in_acc = i_in_valid && !o_in_stall;

    `PIF_ASSERT_NXT(a_load_starts_div, i_clk, i_rst_n, in_acc, upc == U_DIV, "accepted beat did not start digit generation")
    `PIF_ASSERT_IMP(a_hold_on_emit, i_clk, i_rst_n, status.hold, (uword.op == OP_EMIT_MINUS) || (uword.op == OP_EMIT_FILL) || (uword.op == OP_EMIT_TEXT), "sequencer held outside an emitting step")
    `PIF_ASSERT_NXT(a_last_ends_field, i_clk, i_rst_n, status.fire_last, (upc == U_RPAD_CHK) || (upc == U_DONE), "last beat sent before the field was finished")

endmodule

### rtl/core/pif_ucode_rom.sv
// microcode rom of the padded integer formatter: one control word per step
// depends on pif_pkg
module pif_ucode_rom (
    input  pif_pkg::t_upc   i_upc,
    output pif_pkg::t_uword o_uword
);
    import pif_pkg::*;

    always_comb begin
        unique case (i_upc)
            U_IDLE:     o_uword = '{op: OP_LOAD,       cond: C_NO_IN,      target: U_IDLE};
            U_DIV:      o_uword = '{op: OP_DIV,        cond: C_DIV_AGAIN,  target: U_DIV};
            U_SIGN:     o_uword = '{op: OP_SIGN,       cond: C_NEVER,      target: U_IDLE};
            U_FILL:     o_uword = '{op: OP_FILL,       cond: C_NEVER,      target: U_IDLE};
            U_MINUS:    o_uword = '{op: OP_EMIT_MINUS, cond: C_NEVER,      target: U_IDLE};
            U_PAD_CHK:  o_uword = '{op: OP_NONE,       cond: C_LEFT_JUST,  target: U_TEXT};
            U_LPAD:     o_uword = '{op: OP_EMIT_FILL,  cond: C_FILL_MORE,  target: U_LPAD};
            U_TEXT:     o_uword = '{op: OP_EMIT_TEXT,  cond: C_TEXT_MORE,  target: U_TEXT};
            U_RPAD_CHK: o_uword = '{op: OP_NONE,       cond: C_RIGHT_JUST, target: U_IDLE};
            U_RPAD:     o_uword = '{op: OP_EMIT_FILL,  cond: C_FILL_MORE,  target: U_RPAD};
            U_DONE:     o_uword = '{op: OP_NONE,       cond: C_ALWAYS,     target: U_IDLE};
            // unused steps fall back to idle
            default:    o_uword = '{op: OP_NONE,       cond: C_ALWAYS,     target: U_IDLE};
        endcase
    end

endmodule

### rtl/core/pif_sequencer.sv
// step counter with conditional jumps for the padded integer formatter
// depends on pif_pkg; flags come from the datapath status
module pif_sequencer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pif_pkg::t_uword     i_uword,
    input  pif_pkg::t_dp_status i_status,
    output pif_pkg::t_upc       o_upc
);
    import pif_pkg::*;

    t_upc r_upc;
    t_upc n_upc;
    logic cond_true;

    always_comb begin
        unique case (i_uword.cond)
            C_NEVER:      cond_true = 1'b0;
            C_ALWAYS:     cond_true = 1'b1;
            C_NO_IN:      cond_true = i_status.no_in;
            C_DIV_AGAIN:  cond_true = i_status.div_again;
            C_LEFT_JUST:  cond_true = i_status.left_just;
            C_RIGHT_JUST: cond_true = !i_status.left_just;
            C_FILL_MORE:  cond_true = i_status.fill_more;
            C_TEXT_MORE:  cond_true = i_status.text_more;
        endcase
    end

    always_comb begin
        priority if (i_status.hold) begin
            // output beat still waiting, repeat this step
            n_upc = r_upc;
        end else if (cond_true) begin
            n_upc = i_uword.target;
        end else begin
            n_upc = r_upc + t_upc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_upc = r_upc;

endmodule

### rtl/core/pif_datapath.sv
// datapath of the padded integer formatter: operand registers, radix divider,
// digit store, pad counters and output register; depends on pif_pkg
module pif_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pif_pkg::t_uword               i_uword,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [pif_pkg::NUM_W-1:0]     i_number,
    input  logic [pif_pkg::RADIX_W-1:0]   i_radix,
    input  logic                          i_signed_mode,
    input  logic [pif_pkg::WIDTH_W-1:0]   i_field_width,
    input  logic [pif_pkg::PAD_W-1:0]     i_pad_mode,
    input  logic                          i_upper_case,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pif_pkg::CHAR_W-1:0]    o_character,
    output logic                          o_last,
    output pif_pkg::t_dp_status           o_status
);
    import pif_pkg::*;

    logic [NUM_W-1:0]       r_mag;
    logic [DIGIT_W-1:0]     r_rem;
    logic [CHUNK_CNT_W-1:0] r_chunk;
    logic [RADIX_W-1:0]     r_radix;
    logic                   r_neg;
    logic [WIDTH_W-1:0]     r_width;
    logic [PAD_W-1:0]       r_pad;
    logic                   r_upper;
    logic [CHAR_W-1:0]      r_text [DIGIT_SLOTS];
    logic [LEN_W-1:0]       r_len;
    logic                   r_lead;
    logic [WIDTH_W-1:0]     r_fill;
    logic                   r_fill_zero;
    logic                   r_out_valid;
    logic [CHAR_W-1:0]      r_char;
    logic                   r_last;

    logic                   in_acc;
    logic [RADIX_W-1:0]     radix_sat;
    logic [WIDTH_W-1:0]     width_sat;
    logic                   neg_load;
    logic [NUM_W-1:0]       mag_load;

    logic [CHUNK_BITS-1:0]  div_top;
    logic [CHUNK_BITS-1:0]  div_quo;
    logic [DIGIT_W-1:0]     div_rem;
    logic [DIGIT_W:0]       div_trial;
    logic [NUM_W-1:0]       mag_next;
    logic                   last_chunk;
    logic                   more_after;
    logic [CHAR_W-1:0]      digit_char;

    logic [LEN_W-1:0]       len_m1;
    logic                   len_room;
    logic                   out_free;
    logic                   emit_need;
    logic                   emit_fire;
    logic [CHAR_W-1:0]      emit_char;
    logic                   emit_last;

    assign o_in_stall = !i_rst_n || (i_uword.op != OP_LOAD);
    assign in_acc     = i_in_valid && !o_in_stall;

    // operand clamping and sign handling at load
    always_comb begin
        priority if (i_radix < RADIX_W'(RADIX_MIN)) begin
            radix_sat = RADIX_W'(RADIX_MIN);
        end else if (i_radix > RADIX_W'(RADIX_MAX)) begin
            radix_sat = RADIX_W'(RADIX_MAX);
        end else begin
            radix_sat = i_radix;
        end
        width_sat = (i_field_width > WIDTH_W'(WIDTH_MAX)) ? WIDTH_W'(WIDTH_MAX) : i_field_width;
        neg_load  = i_signed_mode && (radix_sat == RADIX_W'(RADIX_DEC)) && i_number[NUM_W-1];
        mag_load  = neg_load ? (~i_number + NUM_W'(1)) : i_number;
    end

    // restoring division, one chunk of quotient bits per cycle
    always_comb begin
        div_top = r_mag[NUM_W-1 -: CHUNK_BITS];
        div_rem = (r_chunk == '0) ? '0 : r_rem;
        div_quo = '0;
        div_trial = '0;
        for (int k = CHUNK_BITS - 1; k >= 0; k--) begin
            div_trial = {div_rem, div_top[k]};
            if (div_trial >= r_radix) begin
                div_quo[k] = 1'b1;
                div_trial  = div_trial - r_radix;
            end
            div_rem = div_trial[DIGIT_W-1:0];
        end
        mag_next   = {r_mag[NUM_W-CHUNK_BITS-1:0], div_quo};
        last_chunk = (r_chunk == CHUNK_CNT_W'(CHUNKS - 1));
        more_after = (mag_next != '0) && (r_len < LEN_W'(DIGIT_SLOTS - 1));
        if (div_rem < DIGIT_W'(RADIX_DEC)) begin
            digit_char = CH_ZERO + CHAR_W'(div_rem);
        end else begin
            digit_char = (r_upper ? CH_UPPER_A : CH_LOWER_A) + CHAR_W'(div_rem)
                         - CHAR_W'(RADIX_DEC);
        end
    end

    assign len_m1   = r_len - LEN_W'(1);
    assign len_room = (r_len < LEN_W'(DIGIT_SLOTS));
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        emit_need = 1'b0;
        emit_char = CH_SPACE;
        emit_last = 1'b0;
        unique case (i_uword.op)
            OP_EMIT_MINUS: begin
                emit_need = r_lead;
                emit_char = CH_MINUS;
            end
            OP_EMIT_FILL: begin
                emit_need = (r_fill != '0);
                emit_char = r_fill_zero ? CH_ZERO : CH_SPACE;
                // only a right-hand fill can end the field
                emit_last = r_pad[0] && (r_fill == WIDTH_W'(1));
            end
            OP_EMIT_TEXT: begin
                emit_need = (r_len != '0);
                emit_char = r_text[len_m1[IDX_W-1:0]];
                emit_last = (r_len == LEN_W'(1)) && !(r_pad[0] && (r_fill != '0));
            end
            OP_NONE, OP_LOAD, OP_DIV, OP_SIGN, OP_FILL: begin
                emit_need = 1'b0;
            end
        endcase
        emit_fire = emit_need && out_free;
    end

    always_ff @(posedge i_clk) begin
        unique case (i_uword.op)
            OP_LOAD: begin
                if (in_acc) begin
                    r_mag   <= mag_load;
                    r_chunk <= '0;
                    r_radix <= radix_sat;
                    r_neg   <= neg_load;
                    r_width <= width_sat;
                    r_pad   <= i_pad_mode;
                    r_upper <= i_upper_case;
                    r_len   <= '0;
                    r_lead  <= 1'b0;
                end
            end
            OP_DIV: begin
                r_mag   <= mag_next;
                r_rem   <= div_rem;
                r_chunk <= last_chunk ? '0 : r_chunk + CHUNK_CNT_W'(1);
                if (last_chunk && len_room) begin
                    r_text[r_len[IDX_W-1:0]] <= digit_char;
                    r_len                    <= r_len + LEN_W'(1);
                end
            end
            OP_SIGN: begin
                if (r_neg) begin
                    // zero fill with a width puts the sign ahead of the fill
                    if ((r_width != '0) && r_pad[1]) begin
                        r_lead  <= 1'b1;
                        r_width <= r_width - WIDTH_W'(1);
                    end else if (len_room) begin
                        r_text[r_len[IDX_W-1:0]] <= CH_MINUS;
                        r_len                    <= r_len + LEN_W'(1);
                    end
                end
            end
            OP_FILL: begin
                r_fill      <= (r_width > WIDTH_W'(r_len)) ? r_width - WIDTH_W'(r_len) : '0;
                r_fill_zero <= (r_width != '0) && r_pad[1];
            end
            OP_EMIT_FILL: begin
                if (emit_fire) begin
                    r_fill <= r_fill - WIDTH_W'(1);
                end
            end
            OP_EMIT_TEXT: begin
                if (emit_fire) begin
                    r_len <= len_m1;
                end
            end
            OP_NONE, OP_EMIT_MINUS: begin
            end
        endcase
        if (emit_fire) begin
            r_char <= emit_char;
            r_last <= emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    assign o_status.no_in     = !i_in_valid;
    assign o_status.div_again = !last_chunk || more_after;
    assign o_status.left_just = r_pad[0];
    assign o_status.fill_more = (r_fill > WIDTH_W'(1));
    assign o_status.text_more = (r_len > LEN_W'(1));
    assign o_status.hold      = emit_need && !out_free;
    assign o_status.fire_last = emit_fire && emit_last;

endmodule
